// ===== src/mavg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, register codes and types of the moving average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

	localparam int MAX_WINDOW  = 1024;
	localparam int SAMPLE_BITS = 24;

	// delay line addressing
	localparam int POS_W = $clog2(MAX_WINDOW);

	// configuration register widths
	localparam int WIN_W     = 11;
	localparam int INV_W     = 17;
	localparam int CFG_W     = (WIN_W > INV_W) ? WIN_W : INV_W;
	localparam int CFG_IDX_W = 2;
	localparam int INV_RESET = 65536;

	// wide enough for a window value and for a position plus one
	localparam int CMP_W = ((POS_W + 1) > WIN_W) ? (POS_W + 1) : WIN_W;

	// arithmetic widths
	localparam int SUM_W     = SAMPLE_BITS + POS_W;
	localparam int PROD_W    = SUM_W + INV_W + 1;
	localparam int RND_SHIFT = 16;
	localparam int SH_W      = PROD_W - RND_SHIFT;

	// result queue, a power of two
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW  = 2'd0,
		REG_INVERSE = 2'd1
	} cfg_reg_t;

	// issue control passed from the front end into the datapath
	typedef struct packed {
		logic valid;
		logic filled;
		logic clear;
	} mavg_issue_t;

endpackage

// ===== src/mavg_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_sample_if / mavg_average_if
// Valid/ready channels carrying one sample item or one average item.
// ----------------------------------------------------------------------------
interface mavg_sample_if import mavg_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface mavg_average_if import mavg_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t average;

	modport source (output valid, output average, input ready);
	modport sink   (input valid, input average, output ready);
endinterface

// ===== src/moving_average_filter_top.sv =====
`timescale 1ns / 1ps
// Path: an accepted item passes v_s1, sum_s2 and prod_s3, then the result queue.
// Throughput: one item per cycle while a queue slot is free, set by the single delay
// line RAM read and write per item and the running sum register.
// Reset: arst_n clears the control state, the window to 1 and the reciprocal to 1.0;
// the delay line needs no clearing pass, a wrap flag masks stale entries.
// ----------------------------------------------------------------------------
// moving_average_filter_top
// Recursive boxcar average over the last N samples, scaled by a Q16 reciprocal.
// ----------------------------------------------------------------------------
module moving_average_filter_top import mavg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	mavg_sample_if.sink          samples,
	mavg_average_if.source       averages,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [WIN_W-1:0]   win_q, win_clamp;
	logic [INV_W-1:0]   inv_q;
	logic [POS_W-1:0]   pos_q;
	logic               filled_q;
	logic [FIFO_AW:0]   cnt_q;
	logic [CMP_W-1:0]   pos_inc;
	logic               wrap;
	logic               accept, pop, win_wr;
	mavg_issue_t        issue;
	logic [SAMPLE_BITS-1:0] rdata;
	logic               res_valid;
	sample_t            res_avg;

	assign accept = samples.valid && samples.ready;
	assign pop    = averages.valid && averages.ready;
	assign win_wr = cfg_we && (cfg_idx == REG_WINDOW);

	// Hold off input once every queue slot is spoken for by an item in flight
	// or waiting; the queue can then never overflow.
	assign samples.ready = (cnt_q < (FIFO_AW+1)'(FIFO_DEPTH));

	// Map a window of zero to one and clamp to the delay line length.
	always_comb begin
		if (cfg_wdata[WIN_W-1:0] == '0) begin
			win_clamp = WIN_W'(1);
		end else if (CMP_W'(cfg_wdata[WIN_W-1:0]) > CMP_W'(MAX_WINDOW)) begin
			win_clamp = WIN_W'(MAX_WINDOW);
		end else begin
			win_clamp = cfg_wdata[WIN_W-1:0];
		end
	end

	// Advance the write position, wrapping at the window length.
	assign pos_inc = CMP_W'(pos_q) + CMP_W'(1);
	assign wrap    = (pos_inc >= CMP_W'(win_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= WIN_W'(1);
			inv_q    <= INV_W'(INV_RESET);
			pos_q    <= '0;
			filled_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_WINDOW:  win_q <= win_clamp;
					REG_INVERSE: inv_q <= cfg_wdata[INV_W-1:0];
					default: ;
				endcase
			end
			// A window write restarts the delay line: drop the position and wrap flag.
			if (win_wr) begin
				pos_q    <= '0;
				filled_q <= 1'b0;
			end else if (accept) begin
				if (wrap) begin
					pos_q    <= '0;
					filled_q <= 1'b1;
				end else begin
					pos_q <= pos_inc[POS_W-1:0];
				end
			end
			if (accept && !pop) begin
				cnt_q <= cnt_q + (FIFO_AW+1)'(1);
			end else if (pop && !accept) begin
				cnt_q <= cnt_q - (FIFO_AW+1)'(1);
			end
		end
	end

	// The RAM returns the old entry on a same-address collision, so the item
	// leaving the window is read while the new one is written in the same cycle.
	mavg_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (pos_q),
		.wdata (samples.sample),
		.raddr (pos_q),
		.rdata (rdata)
	);

	assign issue.valid  = accept;
	assign issue.filled = filled_q;
	assign issue.clear  = win_wr;

	mavg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.sample    (samples.sample),
		.rdata     (rdata),
		.inv       (inv_q),
		.res_valid (res_valid),
		.res_avg   (res_avg)
	);

	mavg_ofifo u_ofifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res_avg),
		.pop    (pop),
		.valid  (averages.valid),
		.rdata  (averages.average)
	);

endmodule

// ===== src/mavg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_ram
// Generic simple dual port RAM, registered read, old data on a collision.
// ----------------------------------------------------------------------------
module mavg_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/mavg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_datapath
// Running sum update, reciprocal multiply, rounding and saturation.
// ----------------------------------------------------------------------------
module mavg_datapath import mavg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mavg_issue_t       issue,
	input  sample_t           sample,
	input  logic [SAMPLE_BITS-1:0] rdata,
	input  logic [INV_W-1:0]  inv,
	output logic              res_valid,
	output sample_t           res_avg
);

	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (RND_SHIFT - 1);

	logic                     v_s1, v_s2, v_s3;
	logic                     filled_s1;
	sample_t                  x_s1;
	logic signed [SUM_W-1:0]  sum_q, sum_nx, sum_s2;
	logic signed [PROD_W-1:0] prod_s3, rnd;
	logic signed [SH_W-1:0]   shifted;
	logic [SH_W-SAMPLE_BITS:0] hi;
	sample_t                  old;

	// entries not yet written since the last clear read as zero
	assign old    = filled_s1 ? sample_t'(rdata) : '0;
	assign sum_nx = sum_q - SUM_W'(old) + SUM_W'(x_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			sum_q <= '0;
		end else begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (issue.clear) begin
				sum_q <= '0;
			end else if (v_s1) begin
				sum_q <= sum_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		filled_s1 <= issue.filled;
		x_s1      <= sample;
		sum_s2    <= sum_nx;
		prod_s3   <= sum_s2 * $signed({1'b0, inv});
	end

	// round half up, floor shift, then clamp to the sample range
	assign rnd     = prod_s3 + HALF;
	assign shifted = rnd[PROD_W-1:RND_SHIFT];
	assign hi      = shifted[SH_W-1:SAMPLE_BITS-1];

	always_comb begin
		if ((&hi) || !(|hi)) begin
			res_avg = shifted[SAMPLE_BITS-1:0];
		end else if (shifted[SH_W-1]) begin
			res_avg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			res_avg = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	assign res_valid = v_s3;

endmodule

// ===== src/mavg_ofifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_ofifo
// Result queue between the datapath and the output channel.
// ----------------------------------------------------------------------------
module mavg_ofifo import mavg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  sample_t wdata,
	input  logic    pop,
	output logic    valid,
	output sample_t rdata
);

	sample_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (FIFO_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

endmodule

// ===== src/mavg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_checker
// Port level checks of the moving average filter, bound to the top level.
// ----------------------------------------------------------------------------
module mavg_checker import mavg_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input sample_t out_avg
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("average item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_avg))
		else $error("average item changed while stalled");

	// an empty output turns valid only after an accepted item has passed v_s1, sum_s2 and prod_s3
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("average item without a matching sample item");

	// input back-pressure only ever rises on an accepted item
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("input ready dropped without an accepted item");

endmodule

bind moving_average_filter_top mavg_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (averages.valid),
	.out_ready (averages.ready),
	.out_avg   (averages.average)
);

// ===== bench/tb_moving_average_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_filter_top
// Self-checking bench for the boxcar moving average filter. A directed table
// covers the sample extremes, saturation, rounding and the window register
// corner cases. Random phases follow, each with its own window and gain. Every
// average item is checked against the table or a bench-side running sum model.
// ----------------------------------------------------------------------------
module tb_moving_average_filter_top;
	import mavg_pkg::*;

	// clock and run limits
	localparam int     HALF_PERIOD = 6;
	localparam int     SETTLE      = 8;       // wait that lets the pipeline go quiet
	localparam longint CYCLE_LIMIT = 400000;

	// register indexes that decode to nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// sample range
	localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam longint  L_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint  L_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

	typedef enum logic [0:0] {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	// one line of the directed table: a register write or a sample item,
	// with an optional expected average that can be read off directly
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		sample_t              smp;
		logic                 fixed;
		sample_t              want;
	} row_t;

	localparam int NDIR = 30;

	row_t directed [NDIR] = '{
		// window 1, unity gain after reset: the average is the sample itself
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      24'sd0,       1'b1, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      S_MAX,        1'b1, S_MAX},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      S_MIN,        1'b1, S_MIN},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      -24'sd1,      1'b1, -24'sd1},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      24'sd1,       1'b1, 24'sd1},
		// gain just under two: both extremes saturate
		'{ROW_WRITE,  REG_INVERSE, 17'd131071, 24'sd0,       1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      S_MAX,        1'b1, S_MAX},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      S_MIN,        1'b1, S_MIN},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      24'sd4194304, 1'b0, 24'sd0},
		// zero gain: only the rounding constant is left, which floors to zero
		'{ROW_WRITE,  REG_INVERSE, 17'd0,      24'sd0,       1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      S_MAX,        1'b1, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      S_MIN,        1'b1, 24'sd0},
		// window 2, gain one half: halves round toward plus infinity
		'{ROW_WRITE,  REG_INVERSE, 17'd32768,  24'sd0,       1'b0, 24'sd0},
		'{ROW_WRITE,  REG_WINDOW,  17'd2,      24'sd0,       1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      24'sd3,       1'b1, 24'sd2},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      -24'sd6,      1'b1, -24'sd1},
		// same window written again still empties the line
		'{ROW_WRITE,  REG_WINDOW,  17'd2,      24'sd0,       1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      24'sd5,       1'b1, 24'sd3},
		// window zero behaves as window one
		'{ROW_WRITE,  REG_WINDOW,  17'd0,      24'sd0,       1'b0, 24'sd0},
		'{ROW_WRITE,  REG_INVERSE, 17'd65536,  24'sd0,       1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      24'sd7,       1'b1, 24'sd7},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      -24'sd7,      1'b1, -24'sd7},
		// oversized window clamps to the full line; upper data bits are set too
		'{ROW_WRITE,  REG_WINDOW,  17'h1FFFF,  24'sd0,       1'b0, 24'sd0},
		'{ROW_WRITE,  REG_INVERSE, 17'd64,     24'sd0,       1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      S_MAX,        1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      S_MAX,        1'b0, 24'sd0},
		// writes to undecoded indexes must leave everything alone
		'{ROW_WRITE,  REG_SPARE_2, 17'd5,      24'sd0,       1'b0, 24'sd0},
		'{ROW_WRITE,  REG_SPARE_3, 17'd1,      24'sd0,       1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      S_MIN,        1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_WINDOW,  17'd0,      24'sd12345,   1'b0, 24'sd0}
	};

	// random phases: window written, then items sent; runs longer than their window wrap their line
	localparam int NPHASE = 12;
	int unsigned phase_win [NPHASE] = '{1, 2, 3, 5, 16, 0, 7, 33, 2047, 4, 64, 1024};
	int unsigned phase_len [NPHASE] = '{40, 40, 40, 40, 40, 40, 40, 40, 40, 40, 130, 200};

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	mavg_sample_if  sample_ch ();
	mavg_average_if average_ch ();

	moving_average_filter_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.averages  (average_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// bench copy of the filter state
	sample_t     line_hist [MAX_WINDOW];
	int unsigned line_pos;
	longint      line_sum;
	int unsigned win_len;
	int unsigned inv_gain;

	// averages still owed by the block, oldest first
	sample_t pending_avg [$];
	sample_t head_avg;

	int     tx_idle_pct;
	int     rx_idle_pct;
	int     failures;
	longint cycles;

	// empty the delay line and the running sum
	function automatic void clear_line();
		for (int i = 0; i < MAX_WINDOW; i++)
			line_hist[i] = '0;
		line_pos = 0;
		line_sum = 0;
	endfunction

	// register write as the block decodes it
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		int unsigned n;
		case (idx)
			REG_WINDOW: begin
				n = data[WIN_W-1:0];
				if (n == 0)
					n = 1;
				if (n > MAX_WINDOW)
					n = MAX_WINDOW;
				win_len = n;
				clear_line();
			end
			REG_INVERSE: begin
				inv_gain = data[INV_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// push one sample into the line and return the scaled, rounded mean
	function automatic sample_t next_average(input sample_t x);
		int unsigned pos;
		longint      prod;
		longint      avg;
		pos = line_pos;
		if (pos >= win_len)
			pos = 0;
		line_sum = line_sum - longint'(line_hist[pos]) + longint'(x);
		line_hist[pos] = x;
		pos++;
		if (pos >= win_len)
			pos = 0;
		line_pos = pos;
		prod = line_sum * longint'(inv_gain) + 64'sd32768;
		avg = prod >>> RND_SHIFT;
		if (avg > L_MAX)
			avg = L_MAX;
		if (avg < L_MIN)
			avg = L_MIN;
		return sample_t'(avg);
	endfunction

	// random sample: style 1 leans to full scale, style 2 to negative full scale
	function automatic sample_t pick_sample(input int unsigned style);
		int unsigned k;
		k = $urandom_range(0, 7);
		if (style == 1 && $urandom_range(0, 3) != 0)
			return S_MAX;
		if (style == 2 && $urandom_range(0, 3) != 0)
			return S_MIN;
		case (k)
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return sample_t'(int'($urandom_range(0, 64)) - 32);
			default: return sample_t'($urandom);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// count cycles; abandon the run if the block stops delivering
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver back-pressure, changed on the falling edge only
	always @(negedge clk)
		average_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	// compare every delivered average with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && average_ch.valid && average_ch.ready) begin
			if (pending_avg.size() == 0) begin
				$error("average: expected nothing, actual %0d", average_ch.average);
				failures++;
			end else begin
				head_avg = pending_avg.pop_front();
				if (average_ch.average !== head_avg) begin
					$error("average: expected %0d, actual %0d", head_avg, average_ch.average);
					failures++;
				end
			end
		end
	end

	// offer one sample item, hold it until taken, and log what it should give;
	// enters and leaves on a falling edge
	task automatic send_sample(input sample_t s, input logic fixed, input sample_t want);
		sample_t avg;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		avg = next_average(s);
		pending_avg.push_back(fixed ? want : avg);
		@(negedge clk);
	endtask

	// stop offering items and wait until every owed average is out
	task automatic drain();
		sample_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_avg.size() != 0);
	endtask

	// drain, let the pipeline go quiet, then write one register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		drain();
		repeat (SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic set_mode(input int phase);
		if (phase < 4) begin
			tx_idle_pct = 34;
			rx_idle_pct = 55;
		end else if (phase < 8) begin
			tx_idle_pct = 55;
			rx_idle_pct = 34;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	initial begin
		int unsigned      n_eff;
		int unsigned      style;
		logic [CFG_W-1:0] gain;
		logic [CFG_W-1:0] wdata;

		// known levels on every input from time zero
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = '0;
		cfg_wdata        = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		average_ch.ready = 1'b0;
		failures         = 0;
		cycles           = 0;
		win_len          = 1;
		inv_gain         = INV_RESET;
		clear_line();
		set_mode(0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int r = 0; r < NDIR; r++) begin
			if (directed[r].kind == ROW_WRITE)
				write_reg(directed[r].idx, directed[r].data);
			else
				send_sample(directed[r].smp, directed[r].fixed, directed[r].want);
		end

		// random phases
		for (int p = 0; p < NPHASE; p++) begin
			set_mode(p);
			n_eff = (phase_win[p] & 11'h7FF) == 0 ? 1 :
				((phase_win[p] & 11'h7FF) > MAX_WINDOW ? MAX_WINDOW : (phase_win[p] & 11'h7FF));
			case ($urandom_range(0, 5))
				0:       gain = CFG_W'($urandom_range(0, 131071));
				1:       gain = 17'd131071;
				2:       gain = 17'd0;
				default: gain = CFG_W'((65536 + n_eff / 2) / n_eff);
			endcase
			// scatter junk into the data bits above the window field
			wdata = CFG_W'($urandom & 17'h1F800) | phase_win[p][CFG_W-1:0];
			if ($urandom_range(0, 1) != 0) begin
				write_reg(REG_INVERSE, gain);
				write_reg(REG_WINDOW, wdata);
			end else begin
				write_reg(REG_WINDOW, wdata);
				write_reg(REG_INVERSE, gain);
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_WINDOW, wdata);
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
			style = $urandom_range(0, 2);
			for (int i = 0; i < phase_len[p]; i++) begin
				// now and then hold off until the block has caught up
				if ($urandom_range(0, 39) == 0)
					drain();
				send_sample(pick_sample(style), 1'b0, '0);
			end
		end

		drain();
		repeat (2 * SETTLE) @(negedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
src/mavg_pkg.sv
src/mavg_stream_if.sv
src/mavg_ram.sv
src/mavg_datapath.sv
src/mavg_ofifo.sv
src/moving_average_filter_top.sv
src/mavg_checker.sv
bench/tb_moving_average_filter_top.sv
